[rtl/fir_filter_loaded_taps_defines.svh]
// ----------------------------------------------------------------------------
// fir_filter_loaded_taps assertion macros
// Clocked property checks used across the FIR block; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_LOADED_TAPS_DEFINES_SVH
`define FIR_FILTER_LOADED_TAPS_DEFINES_SVH

`ifndef SYNTHESIS

// expr holds at every edge out of reset
`define FLTP_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");

// cons holds in the same cycle as ante
`define FLTP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// cons holds in the cycle after ante
`define FLTP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`else

`define FLTP_ASSERT_ALWAYS(lbl, expr)
`define FLTP_ASSERT_IMPLY(lbl, ante, cons)
`define FLTP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/fltp_pkg.sv]
// ----------------------------------------------------------------------------
// fltp_pkg
// Shared constants, state encoding and control structs for the FIR block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fltp_pkg;

    localparam int MAX_TAPS          = 512;
    localparam int SAMPLE_BITS       = 16;
    localparam int TAP_BITS          = 24;
    localparam int TAP_FRACTION_BITS = 16;
    localparam int TAP_COUNT_BITS    = 10;

    localparam int ADDR_BITS = $clog2(MAX_TAPS);
    localparam int CNT_BITS  = ADDR_BITS + 1;
    localparam int PROD_BITS = SAMPLE_BITS + TAP_BITS;
    localparam int ACC_BITS  = PROD_BITS + ADDR_BITS;
    localparam int RES_BITS  = ACC_BITS - TAP_FRACTION_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } fltp_state_t;

    typedef enum logic {
        KIND_COEF   = 1'b0,
        KIND_SAMPLE = 1'b1
    } fltp_kind_t;

    // sequencer -> datapath
    typedef struct packed {
        logic clear;   // start of a new sample
        logic rd_en;   // memory read issued this cycle
        logic live;    // history entry of this read was written
        logic load;    // capture the finished result
    } fltp_mac_ctrl_t;

    // datapath -> sequencer
    typedef struct packed {
        logic busy;      // reads or products still in flight
        logic out_free;  // output register can take a result
    } fltp_mac_stat_t;

endpackage

`default_nettype wire

[rtl/fltp_ram.sv]
// ----------------------------------------------------------------------------
// fltp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fltp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/fltp_ctrl.sv]
// ----------------------------------------------------------------------------
// fltp_ctrl
// Input handshake, tap sequencer and memory addressing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fir_filter_loaded_taps_defines.svh"

module fltp_ctrl
    import fltp_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [TAP_COUNT_BITS-1:0] cfg_wr_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      kind,
    input  wire logic [ADDR_BITS-1:0]      tap_index,
    output logic                           coef_wr_en,
    output logic                           hist_wr_en,
    output logic      [ADDR_BITS-1:0]      hist_wr_addr,
    output logic      [ADDR_BITS-1:0]      coef_rd_addr,
    output logic      [ADDR_BITS-1:0]      hist_rd_addr,
    output fltp_mac_ctrl_t                 mac_ctrl,
    input  wire fltp_mac_stat_t            mac_stat
);

    fltp_state_t               state_reg, state_next;
    logic [TAP_COUNT_BITS-1:0] tap_count_reg;
    logic [ADDR_BITS-1:0]      newest_reg, newest_next;
    logic [CNT_BITS-1:0]       fill_reg;
    logic [CNT_BITS-1:0]       used_reg, used_next;
    logic [ADDR_BITS-1:0]      t_reg;

    logic accept;
    logic accept_sample;
    logic last_tap;

    assign accept        = in_valid && in_ready;
    assign accept_sample = accept && (fltp_kind_t'(kind) == KIND_SAMPLE);
    assign last_tap      = (CNT_BITS'(t_reg) == (used_reg - CNT_BITS'(1)));

    // circular advance of the newest slot
    assign newest_next = (newest_reg == ADDR_BITS'(MAX_TAPS - 1)) ?
                         '0 : (newest_reg + ADDR_BITS'(1));

    // zero taps runs one, too many runs all
    always_comb
    begin
        priority if (tap_count_reg == '0)
        begin
            used_next = CNT_BITS'(1);
        end
        else if (32'(tap_count_reg) > MAX_TAPS)
        begin
            used_next = CNT_BITS'(MAX_TAPS);
        end
        else
        begin
            used_next = CNT_BITS'(tap_count_reg);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_sample)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_tap)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!mac_stat.busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (mac_stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready       = 1'b0;
        mac_ctrl.rd_en = 1'b0;
        mac_ctrl.load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_ready       = 1'b1;
            ST_RUN:    mac_ctrl.rd_en = 1'b1;
            ST_DRAIN:  mac_ctrl.rd_en = 1'b0;
            ST_FINISH: mac_ctrl.load  = mac_stat.out_free;
            default:   in_ready       = 1'b0;
        endcase
        mac_ctrl.clear = accept_sample;
        mac_ctrl.live  = (CNT_BITS'(t_reg) < fill_reg);
    end

    // out-of-range indexes are dropped
    assign coef_wr_en   = accept && (fltp_kind_t'(kind) == KIND_COEF) &&
                          (CNT_BITS'(tap_index) < CNT_BITS'(MAX_TAPS));
    assign hist_wr_en   = accept_sample;
    assign hist_wr_addr = newest_next;
    assign coef_rd_addr = t_reg;
    assign hist_rd_addr = (newest_reg >= t_reg) ? (newest_reg - t_reg) :
                          (newest_reg + ADDR_BITS'(MAX_TAPS) - t_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_count_reg <= TAP_COUNT_BITS'(MAX_TAPS);
            newest_reg    <= '0;
            fill_reg      <= '0;
            used_reg      <= CNT_BITS'(1);
            t_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                tap_count_reg <= cfg_wr_data;
            end
            if (accept_sample)
            begin
                newest_reg <= newest_next;
                used_reg   <= used_next;
                t_reg      <= '0;
                if (fill_reg != CNT_BITS'(MAX_TAPS))
                begin
                    fill_reg <= fill_reg + CNT_BITS'(1);
                end
            end
            else if (state_reg == ST_RUN)
            begin
                t_reg <= t_reg + ADDR_BITS'(1);
            end
        end
    end

    `FLTP_ASSERT_IMPLY(a_tap_in_range, state_reg == ST_RUN, CNT_BITS'(t_reg) < used_reg)
    `FLTP_ASSERT_ALWAYS(a_fill_bounded, fill_reg <= CNT_BITS'(MAX_TAPS))
    `FLTP_ASSERT_NEXT(a_sample_starts, accept_sample, state_reg == ST_RUN && t_reg == '0)

endmodule

`default_nettype wire

[rtl/fltp_mac.sv]
// ----------------------------------------------------------------------------
// fltp_mac
// Multiply-accumulate datapath, truncation, saturation and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fir_filter_loaded_taps_defines.svh"

module fltp_mac
    import fltp_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fltp_mac_ctrl_t                mac_ctrl,
    output fltp_mac_stat_t                     mac_stat,
    input  wire logic signed [TAP_BITS-1:0]    coef_rd,
    input  wire logic signed [SAMPLE_BITS-1:0] hist_rd,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed      [SAMPLE_BITS-1:0] sample_out,
    output logic                               clipped
);

    localparam logic signed [ACC_BITS-1:0] RND_BIAS =
        ACC_BITS'((2 ** TAP_FRACTION_BITS) - 1);
    localparam logic signed [RES_BITS-1:0] RES_HI =
        RES_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RES_BITS-1:0] RES_LO =
        RES_BITS'(-(2 ** (SAMPLE_BITS - 1)));

    logic                          rd_pend_reg;
    logic                          live_d_reg;
    logic                          prod_pend_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;
    logic                          clipped_reg;

    logic signed [ACC_BITS-1:0]    biased;
    logic signed [RES_BITS-1:0]    res;
    logic signed [SAMPLE_BITS-1:0] sample_next;
    logic                          clipped_next;

    // negative sums get the bias so the shift rounds toward zero
    assign biased = acc_reg[ACC_BITS-1] ? (acc_reg + RND_BIAS) : acc_reg;
    assign res    = RES_BITS'(biased >>> TAP_FRACTION_BITS);

    always_comb
    begin
        priority if (res > RES_HI)
        begin
            sample_next  = SAMPLE_BITS'(RES_HI);
            clipped_next = 1'b1;
        end
        else if (res < RES_LO)
        begin
            sample_next  = SAMPLE_BITS'(RES_LO);
            clipped_next = 1'b1;
        end
        else
        begin
            sample_next  = SAMPLE_BITS'(res);
            clipped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg   <= 1'b0;
            prod_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg   <= mac_ctrl.rd_en;
            prod_pend_reg <= rd_pend_reg;
            if (mac_ctrl.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        live_d_reg <= mac_ctrl.live;
        // slots never written since reset read as zero
        prod_reg   <= live_d_reg ?
                      (PROD_BITS'(coef_rd) * PROD_BITS'(hist_rd)) : '0;
        if (mac_ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_pend_reg)
        begin
            acc_reg <= acc_reg + ACC_BITS'(prod_reg);
        end
        if (mac_ctrl.load)
        begin
            sample_out_reg <= sample_next;
            clipped_reg    <= clipped_next;
        end
    end

    assign mac_stat.busy     = rd_pend_reg || prod_pend_reg;
    assign mac_stat.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

    `FLTP_ASSERT_IMPLY(a_clear_when_empty, mac_ctrl.clear, !rd_pend_reg && !prod_pend_reg)
    `FLTP_ASSERT_IMPLY(a_load_into_free, mac_ctrl.load, !out_valid_reg || out_ready)

endmodule

`default_nettype wire

[rtl/fir_filter_loaded_taps.sv]
// ----------------------------------------------------------------------------
// fir_filter_loaded_taps
// Direct-form FIR filter, 16-bit audio, run-time loaded Q7.16 coefficients.
// ----------------------------------------------------------------------------
// A kind-0 transfer writes one coefficient into the coefficient RAM and
// produces no result. A kind-1 transfer pushes a sample into the
// circular history RAM and produces one filtered sample. One shared
// multiply-accumulate walks the N taps one per cycle, where N is tap_count
// clamped to 1..512, fed by the single read port of each RAM; the pipeline
// then drains through the RAM read and product registers, and a final step
// rounds, saturates and loads the output register. A result waiting in the
// output register does not block the next transfer; once the following
// sample is also finished, the block holds in its final step, taking no
// input, until out_ready. Every coefficient the active taps use must be
// written before the first sample; the history starts out all zero after
// reset (a fill count masks slots not yet written, so no clearing pass is
// needed). tap_count is to be written through cfg_wr_en/cfg_wr_data only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fir_filter_loaded_taps
    import fltp_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // tap_count register
    input  wire logic                          cfg_wr_en,
    input  wire logic [TAP_COUNT_BITS-1:0]     cfg_wr_data,

    // input channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          kind,
    input  wire logic [ADDR_BITS-1:0]          tap_index,
    input  wire logic signed [TAP_BITS-1:0]    tap_value,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,

    // result channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0]      sample_out,
    output logic                               clipped
);

    logic                   coef_wr_en;
    logic                   hist_wr_en;
    logic [ADDR_BITS-1:0]   hist_wr_addr;
    logic [ADDR_BITS-1:0]   coef_rd_addr;
    logic [ADDR_BITS-1:0]   hist_rd_addr;
    logic [TAP_BITS-1:0]    coef_rd;
    logic [SAMPLE_BITS-1:0] hist_rd;
    fltp_mac_ctrl_t         mac_ctrl;
    fltp_mac_stat_t         mac_stat;

    // sequencer: handshake, tap counter, history pointer and fill count
    fltp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .tap_index    (tap_index),
        .coef_wr_en   (coef_wr_en),
        .hist_wr_en   (hist_wr_en),
        .hist_wr_addr (hist_wr_addr),
        .coef_rd_addr (coef_rd_addr),
        .hist_rd_addr (hist_rd_addr),
        .mac_ctrl     (mac_ctrl),
        .mac_stat     (mac_stat)
    );

    // coefficients, indexed by tap position
    fltp_ram #(
        .WIDTH (TAP_BITS),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (coef_wr_en),
        .wr_addr (tap_index),
        .wr_data (tap_value),
        .rd_en   (mac_ctrl.rd_en),
        .rd_addr (coef_rd_addr),
        .rd_data (coef_rd)
    );

    // circular sample history; the sample is written on its accept edge,
    // ahead of the first tap read, so no forwarding is needed
    fltp_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (hist_wr_en),
        .wr_addr (hist_wr_addr),
        .wr_data (sample_in),
        .rd_en   (mac_ctrl.rd_en),
        .rd_addr (hist_rd_addr),
        .rd_data (hist_rd)
    );

    // multiply, accumulate, truncate toward zero, saturate, output register
    fltp_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .mac_ctrl   (mac_ctrl),
        .mac_stat   (mac_stat),
        .coef_rd    ($signed(coef_rd)),
        .hist_rd    ($signed(hist_rd)),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .clipped    (clipped)
    );

endmodule

`default_nettype wire
